### design/hsv_saturation_value_adjust_assert.svh
// assertion macros for the hsv saturation/value adjust block
`ifndef HSV_SATURATION_VALUE_ADJUST_ASSERT_SVH
`define HSV_SATURATION_VALUE_ADJUST_ASSERT_SVH

`ifndef SYNTHESIS
`define HSVA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsva assertion failed");
`define HSVA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hsva reset assertion failed");
`else
`define HSVA_ASSERT(lbl, prop)
`define HSVA_ASSERT_RST(lbl, prop)
`endif

`endif

### design/hsva_pkg.sv
package hsva_pkg;

    localparam int FRACTION_BITS = 16;

    localparam logic [6:0] SLIDER_MID = 7'd50;

    typedef enum logic [1:0] {
        CFG_SATURATION = 2'd0,
        CFG_VALUE      = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pixel_out;

    // elaboration-time table entries
    function automatic longint value_scale(input int mx, input int fbits);
        longint num;
        num = longint'(mx) <<< fbits;
        return num / 255;
    endfunction

    function automatic longint curve_scale(input int pos, input int fbits);
        longint d;
        longint num;
        d = (pos > 50) ? longint'(pos - 50) : longint'(50 - pos);
        num = (d * d * d) <<< fbits;
        if (d > 50) begin
            return 0;
        end
        return num / 125000;
    endfunction

endpackage

### design/hsva_to_hsv.sv
`include "hsv_saturation_value_adjust_assert.svh"

module hsva_to_hsv #(
    parameter int F = hsva_pkg::FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  hsva_pkg::t_pixel_in  i_pixel,
    output logic                 o_valid,
    output logic [7:0]           o_s_num,
    output logic [7:0]           o_s_den,
    output logic [16:0]          o_h_num,
    output logic [16:0]          o_h_den,
    output logic [F:0]           o_v
);

    localparam int VW = F + 1;

    logic [F:0] w_vtab [0:255];

    for (genvar k = 0; k < 256; k++) begin : g_vtab
        localparam logic [F:0] C_V = VW'(hsva_pkg::value_scale(k, F));
        assign w_vtab[k] = C_V;
    end

    logic [7:0]         w_r, w_g, w_b, w_mx, w_mn, w_df;
    logic signed [19:0] w_rs, w_gs, w_bs, w_ds, w_hnum, w_hden;

    assign w_r = i_pixel.red_in;
    assign w_g = i_pixel.green_in;
    assign w_b = i_pixel.blue_in;

    always_comb begin
        w_mx = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_df = w_mx - w_mn;
        w_rs = $signed({12'd0, w_r});
        w_gs = $signed({12'd0, w_g});
        w_bs = $signed({12'd0, w_b});
        w_ds = $signed({12'd0, w_df});
        w_hden = 20'sd360 * w_ds;
        priority if (w_r == w_mx) begin
            w_hnum = 20'sd60 * (w_gs - w_bs);
        end else if (w_g == w_mx) begin
            w_hnum = 20'sd120 * w_ds + 20'sd60 * (w_bs - w_rs);
        end else begin
            w_hnum = 20'sd240 * w_ds + 20'sd60 * (w_rs - w_gs);
        end
        if (w_hnum < 0) w_hnum = w_hnum + w_hden;
    end

    logic r_valid;
    logic [7:0]  r_s_num, r_s_den;
    logic [16:0] r_h_num, r_h_den;
    logic [F:0]  r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_num <= w_df;
            r_s_den <= (w_mx == 8'd0) ? 8'd1 : w_mx;
            r_h_num <= (w_df == 8'd0) ? 17'd0 : w_hnum[16:0];
            r_h_den <= (w_df == 8'd0) ? 17'd1 : w_hden[16:0];
            r_v     <= w_vtab[w_mx];
        end
    end

    assign o_valid = r_valid;
    assign o_s_num = r_s_num;
    assign o_s_den = r_s_den;
    assign o_h_num = r_h_num;
    assign o_h_den = r_h_den;
    assign o_v     = r_v;

endmodule

### design/hsva_div.sv
`include "hsv_saturation_value_adjust_assert.svh"

module hsva_div #(
    parameter int F      = hsva_pkg::FRACTION_BITS,
    parameter int PASS_W = hsva_pkg::FRACTION_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [7:0]        i_s_num,
    input  logic [7:0]        i_s_den,
    input  logic [16:0]       i_h_num,
    input  logic [16:0]       i_h_den,
    input  logic [PASS_W-1:0] i_pass,
    output logic              o_valid,
    output logic [F:0]        o_s,
    output logic [F-1:0]      o_h,
    output logic [PASS_W-1:0] o_pass
);

    logic              r_valid [0:F];
    logic [8:0]        r_rs    [0:F];
    logic [17:0]       r_rh    [0:F];
    logic [7:0]        r_ds    [0:F];
    logic [16:0]       r_dh    [0:F];
    logic [F:0]        r_qs    [0:F];
    logic [F:0]        r_qh    [0:F];
    logic [PASS_W-1:0] r_pass  [0:F];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k <= F; k++) begin : g_stage
        logic [8:0]        w_rs_in, n_rs;
        logic [17:0]       w_rh_in, n_rh;
        logic [7:0]        w_ds;
        logic [16:0]       w_dh;
        logic [F:0]        w_qs_in, w_qh_in, n_qs, n_qh;
        logic [PASS_W-1:0] w_pass;
        logic              w_valid;

        if (k == 0) begin : g_first
            assign w_rs_in = {1'b0, i_s_num};
            assign w_rh_in = {1'b0, i_h_num};
            assign w_ds    = i_s_den;
            assign w_dh    = i_h_den;
            assign w_qs_in = '0;
            assign w_qh_in = '0;
            assign w_pass  = i_pass;
            assign w_valid = i_valid;
        end else begin : g_next
            assign w_rs_in = {r_rs[k-1][7:0], 1'b0};
            assign w_rh_in = {r_rh[k-1][16:0], 1'b0};
            assign w_ds    = r_ds[k-1];
            assign w_dh    = r_dh[k-1];
            assign w_qs_in = r_qs[k-1];
            assign w_qh_in = r_qh[k-1];
            assign w_pass  = r_pass[k-1];
            assign w_valid = r_valid[k-1];
        end

        always_comb begin
            n_qs = w_qs_in;
            n_qh = w_qh_in;
            if (w_rs_in >= {1'b0, w_ds}) begin
                n_rs = w_rs_in - {1'b0, w_ds};
                n_qs[F-k] = 1'b1;
            end else begin
                n_rs = w_rs_in;
            end
            if (w_rh_in >= {1'b0, w_dh}) begin
                n_rh = w_rh_in - {1'b0, w_dh};
                n_qh[F-k] = 1'b1;
            end else begin
                n_rh = w_rh_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rs[k]   <= n_rs;
                r_rh[k]   <= n_rh;
                r_ds[k]   <= w_ds;
                r_dh[k]   <= w_dh;
                r_qs[k]   <= n_qs;
                r_qh[k]   <= n_qh;
                r_pass[k] <= w_pass;
            end
        end
    end

    assign o_valid = r_valid[F];
    assign o_s     = r_qs[F];
    assign o_h     = r_qh[F][F-1:0];
    assign o_pass  = r_pass[F];

    `HSVA_ASSERT(a_rem_s_bound, r_valid[F] |-> r_rs[F] < {1'b0, r_ds[F]})
    `HSVA_ASSERT(a_rem_h_bound, r_valid[F] |-> r_rh[F] < {1'b0, r_dh[F]})

endmodule

### design/hsva_adjust.sv
module hsva_adjust #(
    parameter int F = hsva_pkg::FRACTION_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [F:0]   i_s,
    input  logic [F-1:0] i_h,
    input  logic [F:0]   i_v,
    input  logic [6:0]   i_sat_pos,
    input  logic [6:0]   i_val_pos,
    output logic         o_valid,
    output logic [F:0]   o_s,
    output logic [F-1:0] o_h,
    output logic [F:0]   o_v
);

    localparam int FW = F + 1;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [F:0] w_ftab [0:127];

    for (genvar k = 0; k < 128; k++) begin : g_ftab
        localparam logic [F:0] C_F = FW'(hsva_pkg::curve_scale(k, F));
        assign w_ftab[k] = C_F;
    end

    logic           w_inc_s, w_inc_v;
    logic [F:0]     w_os, w_ov;
    logic [2*F+1:0] w_ps, w_pv;

    assign w_inc_s = i_sat_pos > hsva_pkg::SLIDER_MID;
    assign w_inc_v = i_val_pos > hsva_pkg::SLIDER_MID;
    assign w_os    = w_inc_s ? ONE - i_s : i_s;
    assign w_ov    = w_inc_v ? ONE - i_v : i_v;
    assign w_ps    = {{FW{1'b0}}, w_ftab[i_sat_pos]} * {{FW{1'b0}}, w_os};
    assign w_pv    = {{FW{1'b0}}, w_ftab[i_val_pos]} * {{FW{1'b0}}, w_ov};

    logic           r_valid_a, r_inc_s, r_inc_v;
    logic [F:0]     r_s, r_v;
    logic [F-1:0]   r_h;
    logic [2*F+1:0] r_ps, r_pv;

    logic           r_valid_b;
    logic [F:0]     r_s_out, r_v_out;
    logic [F-1:0]   r_h_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inc_s <= w_inc_s;
            r_inc_v <= w_inc_v;
            r_s     <= i_s;
            r_v     <= i_v;
            r_h     <= i_h;
            r_ps    <= w_ps;
            r_pv    <= w_pv;
            r_s_out <= r_inc_s ? r_s + r_ps[2*F:F] : r_s - r_ps[2*F:F];
            r_v_out <= r_inc_v ? r_v + r_pv[2*F:F] : r_v - r_pv[2*F:F];
            r_h_out <= r_h;
        end
    end

    assign o_valid = r_valid_b;
    assign o_s     = r_s_out;
    assign o_h     = r_h_out;
    assign o_v     = r_v_out;

endmodule

### design/hsva_to_rgb.sv
`include "hsv_saturation_value_adjust_assert.svh"

module hsva_to_rgb #(
    parameter int F = hsva_pkg::FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [F:0]           i_s,
    input  logic [F-1:0]         i_h,
    input  logic [F:0]           i_v,
    output logic                 o_valid,
    output hsva_pkg::t_pixel_out o_pixel
);

    localparam int HW = F + 3;
    localparam int TW = F + 10;
    localparam int YW = F + 4;
    localparam int SH = F + 8;
    localparam int MW = F + 5;
    localparam logic [HW-1:0] K1 = HW'(1) << F;
    localparam logic [HW-1:0] K2 = HW'(2) << F;
    localparam logic [HW-1:0] K3 = HW'(3) << F;
    localparam logic [HW-1:0] K4 = HW'(4) << F;
    localparam logic [HW-1:0] K5 = HW'(5) << F;
    localparam logic [TW-1:0] B120 = TW'(120) << F;
    localparam logic [TW-1:0] B240 = TW'(240) << F;
    localparam logic [TW-1:0] T360 = TW'(360) << F;
    localparam logic [TW-1:0] DEG  = TW'(360);
    localparam logic [YW-1:0] DIV15 = YW'(15);
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 15);

    function automatic logic [7:0] to_channel(input logic [F:0] x);
        logic [F+8:0] c;
        c = ({8'd0, x} << 8) - {8'd0, x};
        if (c[F+8:F] > 9'd255) begin
            return 8'd255;
        end
        return c[F+7:F];
    endfunction

    // stage 1: s*v and the hue offset
    logic [HW-1:0]     w_h6;
    hsva_pkg::t_sector w_sec;
    logic              w_pos;
    logic [TW-1:0]     w_hd, w_bw;
    logic signed [TW-1:0] w_t;
    logic [2*F+1:0]    w_sv;

    assign w_h6 = ({3'd0, i_h} << 2) + ({3'd0, i_h} << 1);
    assign w_hd = {10'd0, i_h} * DEG;
    assign w_sv = {{(F+1){1'b0}}, i_s} * {{(F+1){1'b0}}, i_v};

    always_comb begin
        priority if (w_h6 > K1 && w_h6 <= K3) begin
            w_sec = hsva_pkg::SEC_GREEN;
        end else if (w_h6 > K3 && w_h6 <= K5) begin
            w_sec = hsva_pkg::SEC_BLUE;
        end else begin
            w_sec = hsva_pkg::SEC_RED;
        end
        w_pos = (i_h != '0 && w_h6 <= K1) || (w_h6 > K2 && w_h6 <= K3) ||
                (w_h6 > K4 && w_h6 <= K5);
        unique case (w_sec)
            hsva_pkg::SEC_GREEN: w_bw = B120;
            hsva_pkg::SEC_BLUE:  w_bw = B240;
            default:             w_bw = '0;
        endcase
        w_t = w_pos ? $signed(w_hd) - $signed(w_bw) : $signed(w_bw) - $signed(w_hd);
        if (w_t < 0) w_t = w_t + $signed(T360);
    end

    logic              r1_valid, r1_pos;
    hsva_pkg::t_sector r1_sec;
    logic [2*F+1:0]    r1_sv;
    logic [F:0]        r1_v;
    logic [F+5:0]      r1_t;

    logic              r2_valid, r2_pos;
    hsva_pkg::t_sector r2_sec;
    logic [F:0]        r2_hi, r2_lo, r2_dq;
    logic [F+5:0]      r2_t;

    logic              r3_valid, r3_pos;
    hsva_pkg::t_sector r3_sec;
    logic [F:0]        r3_hi, r3_lo;
    logic [2*F+6:0]    r3_p;

    logic              r4_valid, r4_pos;
    hsva_pkg::t_sector r4_sec;
    logic [F:0]        r4_hi, r4_lo, r4_q0;
    logic [YW-1:0]     r4_y;

    logic              r5_valid, r5_pos;
    hsva_pkg::t_sector r5_sec;
    logic [7:0]        r5_cmax, r5_cmin, r5_cmid;

    logic                 r6_valid;
    hsva_pkg::t_pixel_out r6_pixel;

    logic [YW-1:0]      w_y;
    logic [YW+MW-1:0]   w_yq;
    logic [YW-1:0]      w_q15, w_rm;
    logic [F:0]         w_q, w_mid;
    hsva_pkg::t_pixel_out n_pixel;

    assign w_y   = r3_p[2*F+5:F+2];
    assign w_yq  = {{MW{1'b0}}, w_y} * {{YW{1'b0}}, RECIP};
    assign w_q15 = ({3'd0, r4_q0} << 4) - {3'd0, r4_q0};
    assign w_rm  = r4_y - w_q15;
    assign w_q   = (w_rm >= DIV15) ? r4_q0 + 1'b1 : r4_q0;
    assign w_mid = r4_lo + w_q;

    always_comb begin
        unique case (r5_sec)
            hsva_pkg::SEC_GREEN: begin
                n_pixel.red_out   = r5_pos ? r5_cmin : r5_cmid;
                n_pixel.green_out = r5_cmax;
                n_pixel.blue_out  = r5_pos ? r5_cmid : r5_cmin;
            end
            hsva_pkg::SEC_BLUE: begin
                n_pixel.red_out   = r5_pos ? r5_cmid : r5_cmin;
                n_pixel.green_out = r5_pos ? r5_cmin : r5_cmid;
                n_pixel.blue_out  = r5_cmax;
            end
            default: begin
                n_pixel.red_out   = r5_cmax;
                n_pixel.green_out = r5_pos ? r5_cmid : r5_cmin;
                n_pixel.blue_out  = r5_pos ? r5_cmin : r5_cmid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sv  <= w_sv;
            r1_v   <= i_v;
            r1_t   <= w_t[F+5:0];
            r1_sec <= w_sec;
            r1_pos <= w_pos;

            r2_hi  <= r1_v;
            r2_lo  <= r1_v - r1_sv[2*F:F];
            r2_dq  <= r1_sv[2*F:F];
            r2_t   <= r1_t;
            r2_sec <= r1_sec;
            r2_pos <= r1_pos;

            r3_p   <= {{(F+1){1'b0}}, r2_t} * {{(F+6){1'b0}}, r2_dq};
            r3_hi  <= r2_hi;
            r3_lo  <= r2_lo;
            r3_sec <= r2_sec;
            r3_pos <= r2_pos;

            r4_y   <= w_y;
            r4_q0  <= w_yq[SH +: F+1];
            r4_hi  <= r3_hi;
            r4_lo  <= r3_lo;
            r4_sec <= r3_sec;
            r4_pos <= r3_pos;

            r5_cmax <= to_channel(r4_hi);
            r5_cmin <= to_channel(r4_lo);
            r5_cmid <= to_channel(w_mid);
            r5_sec  <= r4_sec;
            r5_pos  <= r4_pos;

            r6_pixel <= n_pixel;
        end
    end

    assign o_valid = r6_valid;
    assign o_pixel = r6_pixel;

    `HSVA_ASSERT(a_lo_le_hi, r2_valid |-> r2_lo <= r2_hi)
    `HSVA_ASSERT(a_mid_between, r5_valid |-> r5_cmid <= r5_cmax && r5_cmin <= r5_cmid)

endmodule

### design/hsv_saturation_value_adjust.sv
// RGB pixel saturation/value adjust through HSV. One pixel per clock is
// accepted and one result per clock is delivered while the output is not
// stalled. The pipeline has a register stage for max/min and hue numerator,
// the pipelined saturation and hue dividers with one quotient bit per stage
// (FRACTION_BITS + 1 stages), the slider curve registers and the registers
// of the conversion back to RGB. The whole pipeline advances together and
// holds while a finished pixel waits on the output. Slider registers reset
// to 50 (no change) and are meant to be written while the pipeline is empty.
`include "hsv_saturation_value_adjust_assert.svh"

module hsv_saturation_value_adjust #(
    parameter int FRACTION_BITS = hsva_pkg::FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hsva_pkg::t_pixel_in  i_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsva_pkg::t_pixel_out o_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data
);

    localparam int F = FRACTION_BITS;

    logic       w_en;
    logic [6:0] r_sat_pos, r_val_pos;

    assign w_en        = !o_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_pos <= hsva_pkg::SLIDER_MID;
            r_val_pos <= hsva_pkg::SLIDER_MID;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hsva_pkg::CFG_SATURATION: r_sat_pos <= i_cfg_data;
                hsva_pkg::CFG_VALUE:      r_val_pos <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        w_a_valid;
    logic [7:0]  w_s_num, w_s_den;
    logic [16:0] w_h_num, w_h_den;
    logic [F:0]  w_a_v;

    hsva_to_hsv #(.F(F)) u_to_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_valid (w_a_valid),
        .o_s_num (w_s_num),
        .o_s_den (w_s_den),
        .o_h_num (w_h_num),
        .o_h_den (w_h_den),
        .o_v     (w_a_v)
    );

    logic         w_b_valid;
    logic [F:0]   w_b_s, w_b_v;
    logic [F-1:0] w_b_h;

    hsva_div #(.F(F), .PASS_W(F + 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_valid),
        .i_s_num (w_s_num),
        .i_s_den (w_s_den),
        .i_h_num (w_h_num),
        .i_h_den (w_h_den),
        .i_pass  (w_a_v),
        .o_valid (w_b_valid),
        .o_s     (w_b_s),
        .o_h     (w_b_h),
        .o_pass  (w_b_v)
    );

    logic         w_c_valid;
    logic [F:0]   w_c_s, w_c_v;
    logic [F-1:0] w_c_h;

    hsva_adjust #(.F(F)) u_adjust (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_b_valid),
        .i_s       (w_b_s),
        .i_h       (w_b_h),
        .i_v       (w_b_v),
        .i_sat_pos (r_sat_pos),
        .i_val_pos (r_val_pos),
        .o_valid   (w_c_valid),
        .o_s       (w_c_s),
        .o_h       (w_c_h),
        .o_v       (w_c_v)
    );

    hsva_to_rgb #(.F(F)) u_to_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c_valid),
        .i_s     (w_c_s),
        .i_h     (w_c_h),
        .i_v     (w_c_v),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    `HSVA_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_valid)

endmodule
